@@ rtl/core/ssdh_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdh_pkg
// Shared types, constants and helper functions for the stretch, superpixel
// demosaic and histogram block.
// ----------------------------------------------------------------------------
package ssdh_pkg;

  localparam int COUNT_BITS = 24;
  localparam int HIST_BINS  = 256;
  localparam int BIN_W      = $clog2(HIST_BINS);
  localparam int NUM_W      = 27;   // signed numerator width of the divider
  localparam int DEN_W      = 17;   // divisor width (1 .. 65536)
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam logic [DEN_W-1:0] DenOne = DEN_W'(1);

  // floor(2^24 / 257) + 1: (x * BinRecip257) >> 24 equals x / 257 for any
  // 16-bit x.
  localparam logic [16:0] BinRecip257 = 17'd65281;

  typedef enum logic [1:0] {
    ACT_PROCESS = 2'd0,
    ACT_READ    = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_RSVD    = 2'd3
  } ssdh_action_t;

  typedef enum logic [3:0] {
    CFG_BAYER_MODE   = 4'd0,
    CFG_SAMPLE_BYTES = 4'd1,
    CFG_BLACK_LEVEL  = 4'd2,
    CFG_WHITE_LEVEL  = 4'd3
  } ssdh_cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_MONO = 3'd0,
    MODE_GBRG = 3'd1,
    MODE_RGGB = 3'd2,
    MODE_GRBG = 3'd3,
    MODE_BGGR = 3'd4
  } ssdh_mode_t;

  typedef enum logic [2:0] {
    OP_GRAY = 3'd0,
    OP_RED  = 3'd1,
    OP_BLUE = 3'd2,
    OP_G1   = 3'd3,
    OP_T    = 3'd4
  } ssdh_op_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_START, S_WAIT, S_HRD, S_HUPD, S_DONE
  } ssdh_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] sample_top_left;
    logic [15:0] sample_top_right;
    logic [15:0] sample_bottom_left;
    logic [15:0] sample_bottom_right;
    logic [7:0]  bin_index;
  } ssdh_in_t;

  typedef struct packed {
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [COUNT_BITS-1:0] bin_count;
  } ssdh_out_t;

  typedef struct packed {
    logic [2:0]  bayer_mode;
    logic [1:0]  sample_bytes;
    logic [15:0] black_level;
    logic [15:0] white_level;
  } ssdh_cfg_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    ssdh_op_t op;
    logic     hist_rd;
    logic     hist_fin;
    logic     clr_step;
  } ssdh_cmd_t;

  typedef struct packed {
    logic [1:0] in_action;
    logic       in_colour;
    logic       bytes_ok;
    logic       div_done;
    logic       clr_last;
  } ssdh_stat_t;

  // Quad position of each colour role for a pattern: red, top green,
  // bottom green, blue.
  function automatic logic [1:0] quad_pos(input logic [2:0] mode, input ssdh_op_t op);
    logic [1:0] r, g1, g2, b;
    unique case (mode)
      MODE_GBRG: begin g1 = 2'd0; b = 2'd1; r = 2'd2; g2 = 2'd3; end
      MODE_RGGB: begin r = 2'd0; g1 = 2'd1; g2 = 2'd2; b = 2'd3; end
      MODE_GRBG: begin g1 = 2'd0; r = 2'd1; b = 2'd2; g2 = 2'd3; end
      default: begin b = 2'd0; g1 = 2'd1; g2 = 2'd2; r = 2'd3; end
    endcase
    case (op)
      OP_RED:  return r;
      OP_BLUE: return b;
      OP_G1:   return g1;
      OP_T:    return g2;
      default: return 2'd0;
    endcase
  endfunction

  // (x - black) scaled by 255 or by 1, as a signed numerator.
  function automatic logic signed [NUM_W-1:0] scale_diff(input logic [15:0] x,
      input logic [15:0] blk, input logic k255);
    logic signed [16:0]      diff;
    logic signed [NUM_W-1:0] d;
    diff = $signed({1'b0, x}) - $signed({1'b0, blk});
    d    = {{(NUM_W-17){diff[16]}}, diff};
    return k255 ? (d <<< 8) - d : d;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [NUM_W-1:0] v);
    if (v < 0) return 8'd0;
    if (v > NUM_W'(255)) return 8'd255;
    return v[7:0];
  endfunction

endpackage

@@ rtl/core/ssdh_div.sv @@
// ----------------------------------------------------------------------------
// ssdh_div
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module ssdh_div import ssdh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, acc_r[NUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      acc_nxt  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[NUM_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        acc_nxt = {acc_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        acc_nxt = {acc_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

@@ rtl/core/ssdh_dp.sv @@
// ----------------------------------------------------------------------------
// ssdh_dp
// Datapath: captured item, numerator selection, shared divider, result
// registers and the histogram memory with its clearing counter.
// ----------------------------------------------------------------------------
module ssdh_dp import ssdh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ssdh_cfg_t  cfg,
  input  ssdh_in_t   in_data,
  input  ssdh_cmd_t  cmd,
  output ssdh_stat_t stat,
  output ssdh_out_t  result
);

  ssdh_in_t                item_r;
  logic [15:0]             q_r [4];
  logic [2:0]              mode_r;
  logic                    wide_r;
  logic                    k255_r;
  logic [DEN_W-1:0]        d_r;
  logic [15:0]             blk_r;
  logic signed [NUM_W-1:0] g1_r;
  logic signed [NUM_W-1:0] prod_r;
  logic signed [NUM_W+DEN_W:0] prod_full;
  logic [BIN_W-1:0]        bin_r;
  logic [7:0]              red_r, green_r, blue_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic [COUNT_BITS-1:0]   hist_mem [HIST_BINS];
  logic [COUNT_BITS-1:0]   rdata_r;
  logic [BIN_W-1:0]        clr_cnt_r;
  logic [BIN_W-1:0]        rd_addr;
  logic                    colour_r;

  logic signed [NUM_W-1:0] num;
  logic                    div_done;
  logic signed [NUM_W-1:0] quo;
  logic [17:0]             quad_sum;
  logic                    colour_cfg;
  logic [15:0]             bin_src;
  logic [32:0]             bin_prod;
  logic [BIN_W-1:0]        bin_calc;

  assign colour_cfg = (cfg.bayer_mode >= MODE_GBRG) && (cfg.bayer_mode <= MODE_BGGR);

  assign stat.in_action = in_data.action;
  assign stat.in_colour = colour_cfg;
  assign stat.bytes_ok  = (cfg.sample_bytes == 2'd1) || (cfg.sample_bytes == 2'd2);
  assign stat.div_done  = div_done;
  assign stat.clr_last  = (clr_cnt_r == BIN_W'(HIST_BINS - 1));

  assign quad_sum = 18'(q_r[0]) + 18'(q_r[1]) + 18'(q_r[2]) + 18'(q_r[3]);

  // Histogram bin: the quad sum over four is a shift, and the division by
  // 257 of 16-bit samples is a reciprocal multiplication.
  always_comb begin
    bin_src  = colour_r ? quad_sum[17:2] : q_r[0];
    bin_prod = 33'(bin_src) * 33'(BinRecip257);
    bin_calc = wide_r ? bin_prod[31:24] : bin_src[7:0];
  end

  always_comb begin
    num = scale_diff(q_r[quad_pos(mode_r, cmd.op)], blk_r, k255_r);
    case (cmd.op)
      OP_GRAY: num = scale_diff(q_r[0], blk_r, k255_r);
      OP_T:    num = prod_r + scale_diff(q_r[quad_pos(mode_r, OP_T)], blk_r, k255_r);
      default: ;
    endcase
  end

  ssdh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (d_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign prod_full = g1_r * $signed({1'b0, d_r});

  always_ff @(posedge clk) begin
    prod_r <= prod_full[NUM_W-1:0];
    bin_r  <= bin_calc;
    if (cmd.capture) begin
      item_r   <= in_data;
      mode_r   <= cfg.bayer_mode;
      colour_r <= colour_cfg;
      wide_r   <= (cfg.sample_bytes == 2'd2);
      blk_r    <= cfg.black_level;
      if (cfg.white_level >= cfg.black_level) begin
        d_r    <= DEN_W'({1'b0, cfg.white_level} - {1'b0, cfg.black_level} + 17'd1);
        k255_r <= 1'b1;
      end else begin
        d_r    <= DenOne;
        k255_r <= 1'b0;
      end
      q_r[0] <= (cfg.sample_bytes == 2'd2) ? in_data.sample_top_left
                                           : {8'd0, in_data.sample_top_left[7:0]};
      q_r[1] <= (cfg.sample_bytes == 2'd2) ? in_data.sample_top_right
                                           : {8'd0, in_data.sample_top_right[7:0]};
      q_r[2] <= (cfg.sample_bytes == 2'd2) ? in_data.sample_bottom_left
                                           : {8'd0, in_data.sample_bottom_left[7:0]};
      q_r[3] <= (cfg.sample_bytes == 2'd2) ? in_data.sample_bottom_right
                                           : {8'd0, in_data.sample_bottom_right[7:0]};
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      cnt_r   <= '0;
    end else if (div_done) begin
      case (cmd.op)
        OP_GRAY: begin
          red_r   <= clamp8(quo);
          green_r <= clamp8(quo);
          blue_r  <= clamp8(quo);
        end
        OP_RED:  red_r   <= clamp8(quo);
        OP_BLUE: blue_r  <= clamp8(quo);
        OP_G1:   g1_r    <= quo;
        OP_T:    green_r <= clamp8(quo >>> 1);
        default: ;
      endcase
    end else if (cmd.hist_fin && item_r.action == ACT_READ) begin
      cnt_r <= rdata_r;
    end
  end

  // Histogram memory: one write and one registered read a cycle.
  assign rd_addr = (item_r.action == ACT_READ) ? item_r.bin_index : bin_r;

  always_ff @(posedge clk) begin
    if (cmd.hist_rd) begin
      rdata_r <= hist_mem[rd_addr];
    end
    if (cmd.clr_step) begin
      hist_mem[clr_cnt_r] <= '0;
    end else if (cmd.hist_fin && item_r.action != ACT_READ) begin
      hist_mem[bin_r] <= (rdata_r == '1) ? rdata_r : rdata_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign result.red       = red_r;
  assign result.green     = green_r;
  assign result.blue      = blue_r;
  assign result.bin_count = cnt_r;

endmodule

@@ rtl/core/ssdh_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssdh_ctrl
// Sequencer: clearing sweep, division order per item, histogram access and
// result hand-over.
// ----------------------------------------------------------------------------
module ssdh_ctrl import ssdh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_free,
  input  ssdh_stat_t stat,
  output ssdh_cmd_t  cmd,
  output logic       idle,
  output logic       emit
);

  ssdh_state_t state_r, state_nxt;
  ssdh_op_t    op_r, op_nxt;
  logic        emit_clr_r, emit_clr_nxt;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    emit_clr_nxt = emit_clr_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) begin
        state_nxt = emit_clr_r ? S_DONE : S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        case (stat.in_action)
          ACT_READ: state_nxt = S_HRD;
          ACT_CLEAR: begin
            state_nxt    = S_CLEAR;
            emit_clr_nxt = 1'b1;
          end
          ACT_PROCESS: begin
            if (stat.bytes_ok) begin
              state_nxt = S_PREP;
              op_nxt    = stat.in_colour ? OP_RED : OP_GRAY;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PREP:  state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT: if (stat.div_done) begin
        state_nxt = S_PREP;
        unique case (op_r)
          OP_RED:  op_nxt = OP_BLUE;
          OP_BLUE: op_nxt = OP_G1;
          OP_G1:   op_nxt = OP_T;
          default: state_nxt = S_HRD;
        endcase
      end
      S_HRD:  state_nxt = S_HUPD;
      S_HUPD: state_nxt = S_DONE;
      S_DONE: if (out_free) begin
        state_nxt    = S_IDLE;
        emit_clr_nxt = 1'b0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = op_r;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.div_start = (state_r == S_START);
    cmd.hist_rd   = (state_r == S_HRD);
    cmd.hist_fin  = (state_r == S_HUPD);
    cmd.clr_step  = (state_r == S_CLEAR);
    idle          = (state_r == S_IDLE);
    emit          = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      op_r       <= OP_GRAY;
      emit_clr_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      emit_clr_r <= emit_clr_nxt;
    end
  end

  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && !stat.div_done) |=> (state_r == S_WAIT))
    else $error("sequencer left the divide wait early");

endmodule

@@ rtl/core/stretch_superpixel_debayer_histogram.sv @@
// ----------------------------------------------------------------------------
// stretch_superpixel_debayer_histogram
// Linear stretch of raw samples with superpixel Bayer demosaic and a
// 256-bin brightness histogram.
// ----------------------------------------------------------------------------
// Each input word carries an action and four raw samples. A process word
// with one or two sample bytes yields one gray or superpixel RGB result and
// bumps one histogram bin; a read word returns one bin's count; a clear word
// zeroes the histogram. Each input word yields exactly one result, in order.
// Input and result channels use valid and stall; a word moves on a rising
// edge where valid is high and stall is low. Registers are written through
// the cfg port (index, data) and are always ready; write them only while
// the block is idle.
// The stretch divisions share one serial divider that yields one quotient
// bit a cycle; the bin comes from a shift and a reciprocal multiply. A mono
// word takes one division, a colour word four and a read none; a clear
// sweeps the histogram memory one entry a cycle. One word is in work at a
// time; the next is taken while a finished result waits. After reset the
// histogram memory is swept to zero, during which in_stall is high. A
// stalled receiver holds the result in the output register and, once the
// next word is finished, the block waits for it.
// ----------------------------------------------------------------------------
module stretch_superpixel_debayer_histogram import ssdh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ssdh_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ssdh_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ssdh_cfg_t  cfg_r;
  ssdh_cmd_t  cmd;
  ssdh_stat_t stat;
  ssdh_out_t  result;
  ssdh_out_t  out_data_r;
  logic       out_valid_r;
  logic       out_free;
  logic       idle;
  logic       emit;

  // Configuration registers; indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bayer_mode   <= MODE_MONO;
      cfg_r.sample_bytes <= 2'd1;
      cfg_r.black_level  <= 16'd0;
      cfg_r.white_level  <= 16'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BAYER_MODE:   cfg_r.bayer_mode   <= cfg_data[2:0];
        CFG_SAMPLE_BYTES: cfg_r.sample_bytes <= cfg_data[1:0];
        CFG_BLACK_LEVEL:  cfg_r.black_level  <= cfg_data;
        CFG_WHITE_LEVEL:  cfg_r.white_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  ssdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .emit     (emit)
  );

  ssdh_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  assign in_stall = !idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a word still waiting");

  a_no_accept_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !emit)
    else $error("word accepted while a result was being handed over");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("input taken before the histogram sweep");

endmodule
